>>> hw/rtl/hcd_pkg.sv
// Package for the HTTP chunked body decoder.
// Holds the classified word type and the byte, error and queue constants.
// No dependencies.
package hcd_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_DIGIT    = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_SIZE_END = 3'd3;
  localparam logic [2:0] ERR_DATA_END = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] raw;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
  } hcd_item_t;

  typedef struct packed {
    logic      valid;
    hcd_item_t item;
  } hcd_push_t;

endpackage

>>> hw/rtl/hcd_front.sv
// Front stage of the chunked decoder: accepts raw words and classifies them.
// Depends on hcd_pkg; feeds hcd_queue.
module hcd_front import hcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output hcd_push_t  push
);

  logic      front_valid;
  hcd_item_t front_item;
  hcd_item_t class_item;
  logic      accept;
  logic      pushed;

  always_comb begin
    class_item         = '0;
    class_item.raw     = in_byte;
    class_item.is_cr   = (in_byte == CHAR_CR);
    class_item.is_lf   = (in_byte == CHAR_LF);
    class_item.is_semi = (in_byte == CHAR_SEMI);
    if (in_byte inside {[8'h30:8'h39]}) begin
      class_item.is_hex  = 1'b1;
      class_item.hex_val = in_byte[3:0];
    end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      class_item.is_hex  = 1'b1;
      class_item.hex_val = in_byte[3:0] + 4'd9;
    end
  end

  assign pushed   = front_valid && !q_full;
  assign in_stall = front_valid && q_full;
  assign accept   = in_valid && !in_stall;

  assign push.valid = front_valid;
  assign push.item  = front_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (pushed) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item <= class_item;
    end
  end

endmodule

>>> hw/rtl/hcd_queue.sv
// Short word queue between the front and back stages of the chunked decoder.
// Depends on hcd_pkg.
module hcd_queue import hcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  hcd_push_t push,
  output logic      full,
  output logic      pop_valid,
  output hcd_item_t pop_item,
  input  logic      pop
);

  localparam logic [QPTR_BITS:0] DEPTH_CNT = (QPTR_BITS+1)'(QUEUE_DEPTH);

  hcd_item_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == DEPTH_CNT);
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("queue count above depth");

endmodule

>>> hw/rtl/hcd_back.sv
// Back stage of the chunked decoder: chunk framing state machine and result register.
// Depends on hcd_pkg; drains hcd_queue.
module hcd_back import hcd_pkg::*; #(
  parameter int SIZE_BITS = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  hcd_item_t  q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       data_valid,
  output logic [7:0] data_byte,
  output logic       done_res,
  output logic [2:0] error_code
);

  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_EXT     = 3'd1;
  localparam logic [2:0] PH_SIZE_LF = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_DATA_CR = 3'd4;
  localparam logic [2:0] PH_DATA_LF = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  logic [2:0]           phase;
  logic [2:0]           phase_next;
  logic [SIZE_BITS-1:0] remaining;
  logic [SIZE_BITS-1:0] remaining_next;
  logic [SIZE_BITS-1:0] rem_dec;
  logic                 digit_seen;
  logic                 digit_seen_next;
  logic [2:0]           sticky_error;
  logic [2:0]           sticky_error_next;
  logic                 dv_next;
  logic [7:0]           db_next;

  assign q_pop   = q_valid && (!out_valid || !out_stall);
  assign rem_dec = remaining - 1'b1;

  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    digit_seen_next   = digit_seen;
    sticky_error_next = sticky_error;
    dv_next           = 1'b0;
    db_next           = '0;
    if (sticky_error == ERR_NONE) begin
      case (phase)
        PH_SIZE: begin
          if (q_item.is_hex) begin
            if (|remaining[SIZE_BITS-1 -: 4]) begin
              sticky_error_next = ERR_OVERFLOW;
            end else begin
              remaining_next  = {remaining[SIZE_BITS-5:0], q_item.hex_val};
              digit_seen_next = 1'b1;
            end
          end else if (q_item.is_semi && digit_seen) begin
            phase_next = PH_EXT;
          end else if (q_item.is_cr && digit_seen) begin
            phase_next = PH_SIZE_LF;
          end else begin
            sticky_error_next = ERR_DIGIT;
          end
        end
        PH_EXT: begin
          if (q_item.is_cr) begin
            phase_next = PH_SIZE_LF;
          end
        end
        PH_SIZE_LF: begin
          if (!q_item.is_lf) begin
            sticky_error_next = ERR_SIZE_END;
          end else if (remaining == '0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          dv_next        = 1'b1;
          db_next        = q_item.raw;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (q_item.is_cr) begin
            phase_next = PH_DATA_LF;
          end else begin
            sticky_error_next = ERR_DATA_END;
          end
        end
        PH_DATA_LF: begin
          if (q_item.is_lf) begin
            phase_next      = PH_SIZE;
            remaining_next  = '0;
            digit_seen_next = 1'b0;
          end else begin
            sticky_error_next = ERR_DATA_END;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIZE;
      remaining    <= '0;
      digit_seen   <= 1'b0;
      sticky_error <= ERR_NONE;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase        <= phase_next;
        remaining    <= remaining_next;
        digit_seen   <= digit_seen_next;
        sticky_error <= sticky_error_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_valid <= dv_next;
      data_byte  <= db_next;
      done_res   <= (phase_next == PH_DONE);
      error_code <= sticky_error_next;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    sticky_error != ERR_NONE |=> sticky_error == $past(sticky_error))
    else $error("sticky error changed");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("left done phase");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> error_code == ERR_NONE && !done_res)
    else $error("payload word with error or done");

endmodule

>>> hw/rtl/http_chunked_decoder_top.sv
// HTTP chunked body decoder: one raw word in, one result word out.
// Path: an accepted word passes the front register and the queue before the result register takes it.
// Throughput: one word per cycle while out_stall is low; the framing state machine takes one word per pop.
// A 4-entry queue lets the front keep accepting for a while when the output stalls.
// Reset (rst, synchronous): clears framing state, error, queue, front_valid and out_valid; no clearing pass.
module http_chunked_decoder_top import hcd_pkg::*; #(
  parameter int SIZE_BITS = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       data_valid,
  output logic [7:0] data_byte,
  output logic       done_res,
  output logic [2:0] error_code
);

  hcd_push_t push;
  logic      q_full;
  logic      q_valid;
  hcd_item_t q_item;
  logic      q_pop;

  hcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push)
  );

  hcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop       (q_pop)
  );

  hcd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .done_res   (done_res),
    .error_code (error_code)
  );

endmodule
